[design/gift64_pkg.sv]
package gift64_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 128;
    localparam int RC_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic [3:0] SBOX [16] = '{
        4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
        4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    // Commands from the controller to the round datapath
    typedef struct packed {
        logic load;   // take a new plaintext and reload the key state
        logic round;  // execute one round
        logic store;  // capture this round's result as ciphertext
    } ctrl_cmd_t;

    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = SBOX[x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        int q;
        int dst;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            q   = i & 3;
            dst = 4 * (i >> 4) + 16 * ((3 * ((i >> 2) & 3) + q) & 3) + q;
            r[dst] = x[i];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] ks,
                                                      input logic [RC_W-1:0] rc);
        logic [BLOCK_W-1:0] rk;
        rk = '0;
        for (int i = 0; i < 16; i++) begin
            rk[4*i]     = ks[i];
            rk[4*i + 1] = ks[16 + i];
        end
        for (int i = 0; i < RC_W; i++) begin
            rk[4*i + 3] = rc[i];
        end
        rk[BLOCK_W-1] = 1'b1;
        return rk;
    endfunction

    // Key state {k7..k0} becomes {k1>>>2, k0>>>12, k7..k2}
    function automatic logic [KEY_W-1:0] advance_key(input logic [KEY_W-1:0] ks);
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] w6;
        logic [15:0] w7;
        k0 = ks[15:0];
        k1 = ks[31:16];
        w6 = {k0[11:0], k0[15:12]};
        w7 = {k1[1:0], k1[15:2]};
        return {w7, w6, ks[KEY_W-1:32]};
    endfunction

    function automatic logic [RC_W-1:0] next_constant(input logic [RC_W-1:0] c);
        return {c[RC_W-2:0], ~(c[5] ^ c[4])};
    endfunction

endpackage

[design/gift64_block_encrypt_unit.sv]
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+-------------------------------
// input     | in_valid / in_ready            | plaintext [63:0]
// output    | out_valid / out_ready          | ciphertext [63:0]
// config    | cfg_we (no wait, no read-back) | cfg_index [0], cfg_data [63:0]
//
// A block takes ROUND_COUNT rounds (28 by default): the round datapath does one
// round per cycle unless the output stalls, and the next block is accepted on the cycle of the final round.
// A stalled output holds the final round until the output register is free.
// Reset clears the key registers, the controller and the output valid flag.
// The key in effect is the one present when a block is transferred in.
module gift64_block_encrypt_unit #(
    parameter int ROUND_COUNT = 28
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gift64_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gift64_pkg::BLOCK_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [gift64_pkg::BLOCK_W-1:0]         plaintext,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [gift64_pkg::BLOCK_W-1:0]         ciphertext
);
    import gift64_pkg::*;

    ctrl_cmd_t cmd;

    // Sequence rounds, count them and own the output valid flag
    gift64_ctrl #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold the key, the working block, the key schedule and the result
    gift64_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .plaintext  (plaintext),
        .ciphertext (ciphertext)
    );

    // A new block is loaded exactly when an input transfer happens
    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load == (in_valid && in_ready))
        else $error("load command does not match input transfer");

    // Never overwrite a result that has not been transferred out
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!out_valid || out_ready))
        else $error("result stored over a pending ciphertext");

    // A stored result is presented on the next cycle
    a_store_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> out_valid)
        else $error("stored result not presented");

    // A store always comes with the round that produces it
    a_store_with_round: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> cmd.round)
        else $error("store without a round");

endmodule

[design/gift64_ctrl.sv]
module gift64_ctrl #(
    parameter int ROUND_COUNT = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gift64_pkg::ctrl_cmd_t cmd
);
    import gift64_pkg::*;

    localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUND_COUNT - 1);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             last;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign last     = (cnt_reg == LAST_ROUND);
    assign out_free = !out_valid_reg || out_ready;

    // in_ready is high in every branch that tests in_valid, so in_valid alone marks a transfer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!last)
                begin
                    cmd.round = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    // final round: retire into the output register, overlap next load
                    cmd.round = 1'b1;
                    cmd.store = 1'b1;
                    in_ready  = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/gift64_dp.sv]
module gift64_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gift64_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gift64_pkg::BLOCK_W-1:0]         cfg_data,
    input  gift64_pkg::ctrl_cmd_t                  cmd,
    input  logic [gift64_pkg::BLOCK_W-1:0]         plaintext,
    output logic [gift64_pkg::BLOCK_W-1:0]         ciphertext
);
    import gift64_pkg::*;

    logic [BLOCK_W-1:0] key_low_reg;
    logic [BLOCK_W-1:0] key_high_reg;
    logic [BLOCK_W-1:0] state_reg;
    logic [BLOCK_W-1:0] state_next;
    logic [KEY_W-1:0]   ks_reg;
    logic [KEY_W-1:0]   ks_next;
    logic [RC_W-1:0]    rc_reg;
    logic [RC_W-1:0]    rc_next;
    logic [BLOCK_W-1:0] ct_reg;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // One round: S-box, bit permutation, round-key add; advance key schedule
    assign rc_next    = next_constant(rc_reg);
    assign state_next = perm_layer(sub_layer(state_reg)) ^ round_key(ks_reg, rc_next);
    assign ks_next    = advance_key(ks_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            state_reg <= plaintext;
            ks_reg    <= {key_high_reg, key_low_reg};
            rc_reg    <= '0;
        end
        else if (cmd.round)
        begin
            state_reg <= state_next;
            ks_reg    <= ks_next;
            rc_reg    <= rc_next;
        end
        if (cmd.store)
        begin
            ct_reg <= state_next;
        end
    end

    assign ciphertext = ct_reg;

endmodule
